// ===== rtl/pae_pkg.sv =====
package pae_pkg;
  localparam int TABLE_DEPTH_DEF = 256;
  localparam int STACK_DEPTH_DEF = 64;
  localparam int NUM_STATES_DEF = 64;
  localparam int MAX_PUSH_DEF = 4;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_SYM = 2'd2;
  localparam logic [1:0] CMD_END = 2'd3;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_STUCK = 3'd1;
  localparam logic [2:0] ST_ACCEPT = 3'd2;
  localparam logic [2:0] ST_REJECT = 3'd3;
  localparam logic [2:0] ST_OVFL = 3'd4;

  localparam logic [0:0] CFG_MASK = 1'd0;
  localparam logic [0:0] CFG_LIMIT = 1'd1;

  // stack control code that leaves every slot unchanged
  localparam logic [2:0] SHIFT_KEEP = 3'd7;

  typedef struct packed {
    logic       valid;
    logic [5:0] st;
    logic [7:0] sym;
    logic [7:0] top;
    logic [5:0] nxt;
    logic [2:0] len;
    logic [31:0] push;
  } entry_t;

  // one stack cell control word
  typedef struct packed {
    logic       load;
    logic [2:0] shift;
    logic [7:0] s0;
    logic [7:0] s1;
    logic [7:0] s2;
    logic [7:0] s3;
  } stk_ctl_t;
endpackage

// ===== rtl/pae_if.sv =====
interface pae_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] entry_index;
  logic       entry_valid;
  logic [5:0] match_state;
  logic [7:0] match_symbol;
  logic [7:0] match_top;
  logic [5:0] next_state;
  logic [2:0] push_len;
  logic [31:0] push_symbols;
  logic [7:0] symbol;
  modport source(output valid, cmd, entry_index, entry_valid, match_state, match_symbol,
    match_top, next_state, push_len, push_symbols, symbol, input ready);
  modport sink(input valid, cmd, entry_index, entry_valid, match_state, match_symbol,
    match_top, next_state, push_len, push_symbols, symbol, output ready);
endinterface

interface pae_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [1:0] accept_kind;
  logic [5:0] machine_state;
  logic [6:0] depth_out;
  logic [7:0] top_symbol;
  modport source(output valid, status, accept_kind, machine_state, depth_out, top_symbol,
    input ready);
  modport sink(input valid, status, accept_kind, machine_state, depth_out, top_symbol,
    output ready);
endinterface

// ===== rtl/pae_cell.sv =====
// one stack slot; the stack is a shift chain, slot 0 holds the top
module pae_cell
  import pae_pkg::*;
(
  input  logic     clk,
  input  stk_ctl_t ctl,
  input  logic [7:0] below_i,
  input  logic [7:0] above1_i,
  input  logic [7:0] above2_i,
  input  logic [7:0] above3_i,
  input  logic [7:0] above4_i,
  input  logic [7:0] init_i,
  output logic [7:0] sym_o
);
  logic [7:0] sym_r, sym_nxt;

  // load takes init_i; else shift: 0 pop, 1..4 top replaced by that many symbols, other codes keep
  always_comb begin
    sym_nxt = sym_r;
    if (ctl.load) begin
      sym_nxt = init_i;
    end else begin
      unique case (ctl.shift)
        3'd0: sym_nxt = below_i;
        3'd1: sym_nxt = above1_i;
        3'd2: sym_nxt = above2_i;
        3'd3: sym_nxt = above3_i;
        3'd4: sym_nxt = above4_i;
        default: sym_nxt = sym_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    sym_r <= sym_nxt;
  end

  assign sym_o = sym_r;
endmodule

// ===== rtl/pae_stack.sv =====
module pae_stack
  import pae_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic       clk,
  input  stk_ctl_t   ctl,
  output logic [7:0] top_o
);
  logic [7:0] slot [STACK_DEPTH+1];

  assign slot[STACK_DEPTH] = 8'd0;

  // new-symbol sources in top-first order for a grow by g: slot j<g gets s[g-1-j]
  function automatic logic [7:0] pick(input stk_ctl_t c, input int j, input int g);
    logic [7:0] v;
    v = 8'd0;
    unique case (g - 1 - j)
      0: v = c.s0;
      1: v = c.s1;
      2: v = c.s2;
      default: v = c.s3;
    endcase
    return v;
  endfunction

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [7:0] a1, a2, a3, a4, ini;
    // a_g: value this slot takes when the top is replaced by g symbols
    assign a1 = (i < 1) ? pick(ctl, i, 1) : slot[i];
    assign a2 = (i < 2) ? pick(ctl, i, 2) : slot[(i >= 2) ? i-1 : 0];
    assign a3 = (i < 3) ? pick(ctl, i, 3) : slot[(i >= 3) ? i-2 : 0];
    assign a4 = (i < 4) ? pick(ctl, i, 4) : slot[(i >= 4) ? i-3 : 0];
    // initial load uses the same ordering as a grow by the length
    always_comb begin
      ini = 8'd0;
      unique case (ctl.shift)
        3'd1: ini = a1;
        3'd2: ini = a2;
        3'd3: ini = a3;
        3'd4: ini = a4;
        default: ini = 8'd0;
      endcase
    end
    pae_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .below_i  (slot[i+1]),
      .above1_i (a1),
      .above2_i (a2),
      .above3_i (a3),
      .above4_i (a4),
      .init_i   (ini),
      .sym_o    (slot[i])
    );
  end

  assign top_o = slot[0];
endmodule

// ===== rtl/pushdown_automaton_engine_unit.sv =====
// write, start and stuck items go straight to the result; a symbol scans the table
// entries in order until a match or an unused entry; end of input repeats the scan
// after each applied step, up to the step limit set through CFG_LIMIT
// one word in flight: the next word is taken after the result is taken
// synchronous active-low reset: table entries marked unused, run state cleared
module pushdown_automaton_engine_unit
  import pae_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int NUM_STATES  = NUM_STATES_DEF,
  parameter int MAX_PUSH    = MAX_PUSH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  pae_in_if.sink      in_if,
  pae_out_if.source   out_if,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  localparam int TW = $clog2(TABLE_DEPTH);
  localparam int DW = $clog2(STACK_DEPTH + 1);
  localparam int CAP = (MAX_PUSH < 4) ? MAX_PUSH : 4;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_DONE = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0] fsm_r, fsm_nxt;
  entry_t mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] vld_r;
  entry_t rd_r;
  logic rd_v_r;
  logic [TW:0] idx_r;
  logic [63:0] mask_r;
  logic [9:0] limit_r, cnt_r;
  logic [DW-1:0] depth_r;
  logic [5:0] state_r;
  logic stuck_r, end_r;
  logic [7:0] sym_r;
  logic [2:0] status_r;
  logic [1:0] kind_r;
  logic ov_r;
  logic [2:0] o_status_r;
  logic [1:0] o_kind_r;
  logic [5:0] o_state_r;
  logic [DW-1:0] o_depth_r;
  logic [7:0] o_top_r;
  stk_ctl_t ctl;
  logic [7:0] top;
  logic acc;
  logic [2:0] in_len;
  logic [TW-1:0] wr_idx;
  logic live;
  logic hit;
  logic [DW:0] base, newd;

  function automatic logic [2:0] clamp(input logic [2:0] l);
    return (l > 3'(CAP)) ? 3'(CAP) : l;
  endfunction

  assign in_len = clamp(in_if.push_len);
  assign wr_idx = TW'(in_if.entry_index);
  assign in_if.ready = (fsm_r == S_IDLE) && !ov_r;
  assign acc = in_if.valid && in_if.ready;

  // table memory
  always_ff @(posedge clk) begin
    if (acc && in_if.cmd == CMD_WRITE && 32'(in_if.entry_index) < TABLE_DEPTH) begin
      mem[wr_idx] <= '{in_if.entry_valid, in_if.match_state,
        in_if.match_symbol, in_if.match_top, in_if.next_state, in_len, in_if.push_symbols};
    end
    rd_r <= mem[idx_r[TW-1:0]];
  end

  // entry written and marked in use
  assign live = rd_v_r && rd_r.valid;
  assign hit = rd_r.st == state_r && rd_r.sym == sym_r &&
    ((depth_r == '0) ? (rd_r.top == 8'd0) : (rd_r.top != 8'd0 && rd_r.top == top));
  assign base = (depth_r == '0) ? '0 : ({1'b0, depth_r} - 1'b1);
  assign newd = base + (DW+1)'(rd_r.len);

  always_comb begin
    ctl = '0;
    ctl.shift = SHIFT_KEEP;
    if (acc && in_if.cmd == CMD_START) begin
      ctl.load = 1'b1;
      ctl.shift = in_len;
      {ctl.s3, ctl.s2, ctl.s1, ctl.s0} = in_if.push_symbols;
    end else if (fsm_r == S_CHK && live && hit && !(end_r && cnt_r >= limit_r) &&
                 newd <= (DW+1)'(STACK_DEPTH)) begin
      {ctl.s3, ctl.s2, ctl.s1, ctl.s0} = rd_r.push;
      ctl.shift = rd_r.len;
    end
  end

  pae_stack #(.STACK_DEPTH(STACK_DEPTH)) u_stack (.clk(clk), .ctl(ctl), .top_o(top));

  always_comb begin
    fsm_nxt = fsm_r;
    unique case (fsm_r)
      S_IDLE: if (acc) begin
        fsm_nxt = ((in_if.cmd == CMD_SYM || in_if.cmd == CMD_END) && !stuck_r &&
          !(in_if.cmd == CMD_SYM && in_if.symbol == 8'd0)) ? S_READ : S_OUT;
      end
      S_READ: fsm_nxt = S_CHK;
      S_CHK: begin
        if (live && !hit) begin
          fsm_nxt = S_READ;
        end else if (live && hit && end_r && !(cnt_r >= limit_r) &&
                     !(newd > (DW+1)'(STACK_DEPTH))) begin
          fsm_nxt = S_READ;
        end else begin
          fsm_nxt = S_DONE;
        end
      end
      S_DONE: fsm_nxt = S_OUT;
      S_OUT: fsm_nxt = S_IDLE;
      default: fsm_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsm_r <= S_IDLE;
      vld_r <= '0;
      mask_r <= '0;
      limit_r <= 10'd256;
      depth_r <= '0;
      state_r <= '0;
      stuck_r <= 1'b0;
      ov_r <= 1'b0;
      rd_v_r <= 1'b0;
      idx_r <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MASK: mask_r <= cfg_data;
          CFG_LIMIT: limit_r <= cfg_data[9:0];
          default: ;
        endcase
      end
      if (out_if.valid && out_if.ready) ov_r <= 1'b0;
      unique case (fsm_r)
        S_IDLE: if (acc) begin
          status_r <= ST_OK;
          kind_r <= 2'd0;
          cnt_r <= '0;
          idx_r <= '0;
          end_r <= in_if.cmd == CMD_END;
          sym_r <= (in_if.cmd == CMD_SYM) ? in_if.symbol : 8'd0;
          unique case (in_if.cmd)
            CMD_WRITE: if (32'(in_if.entry_index) < TABLE_DEPTH)
              vld_r[wr_idx] <= 1'b1;
            CMD_START: begin
              depth_r <= DW'(in_len);
              state_r <= '0;
              stuck_r <= 1'b0;
            end
            CMD_SYM: if (stuck_r || in_if.symbol == 8'd0) begin
              status_r <= ST_STUCK;
              stuck_r <= 1'b1;
            end
            default: if (stuck_r) status_r <= ST_REJECT;
          endcase
        end
        S_READ: begin
          rd_v_r <= vld_r[idx_r[TW-1:0]] && (idx_r < (TW+1)'(TABLE_DEPTH));
        end
        default: ;
      endcase
      if (fsm_r == S_CHK) begin
        if (!live) begin
          if (!end_r) begin
            status_r <= ST_STUCK;
            stuck_r <= 1'b1;
          end
        end else if (hit) begin
          if (end_r && cnt_r >= limit_r) begin
            status_r <= ST_REJECT;
            stuck_r <= 1'b1;
          end else if (newd > (DW+1)'(STACK_DEPTH)) begin
            status_r <= ST_OVFL;
            stuck_r <= 1'b1;
          end else begin
            depth_r <= newd[DW-1:0];
            state_r <= rd_r.nxt;
            cnt_r <= cnt_r + 10'd1;
          end
        end
      end
      fsm_r <= fsm_nxt;
      if (fsm_r == S_CHK && live && !hit) begin
        idx_r <= idx_r + 1'b1;
      end
      if (fsm_r == S_CHK && live && hit && end_r && !(cnt_r >= limit_r) &&
          !(newd > (DW+1)'(STACK_DEPTH))) begin
        idx_r <= '0;
      end
      if (fsm_r == S_DONE && end_r && status_r == ST_OK) begin
        kind_r <= {(32'(state_r) < NUM_STATES) && mask_r[state_r], depth_r == '0};
        status_r <= ((depth_r == '0) || ((32'(state_r) < NUM_STATES) && mask_r[state_r]))
          ? ST_ACCEPT : ST_REJECT;
      end
      if (fsm_r == S_OUT) ov_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (fsm_r == S_OUT) begin
      o_status_r <= status_r;
      o_kind_r <= kind_r;
      o_state_r <= state_r;
      o_depth_r <= depth_r;
      o_top_r <= (depth_r == '0) ? 8'd0 : top;
    end
  end

  assign out_if.valid = ov_r;
  assign out_if.status = o_status_r;
  assign out_if.accept_kind = o_kind_r;
  assign out_if.machine_state = o_state_r;
  assign out_if.depth_out = 7'(o_depth_r);
  assign out_if.top_symbol = o_top_r;

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (fsm_r != S_IDLE) |-> !in_if.ready) else $error("accept while busy");
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(depth_r) <= STACK_DEPTH)) else $error("depth over bound");
  a_out_after: assert property (@(posedge clk) disable iff (!rst_n)
    (fsm_r == S_OUT) |=> out_if.valid) else $error("result not shown");
`endif
endmodule

// ===== tb/tb_pushdown_automaton_engine_unit.sv =====
module tb_pushdown_automaton_engine_unit;
  import pae_pkg::*;

  localparam int RUN_LIMIT = 40000000;

  typedef struct {
    logic [1:0]  cmd;
    logic [7:0]  idx;
    logic        ev;
    logic [5:0]  st;
    logic [7:0]  msym;
    logic [7:0]  mtop;
    logic [5:0]  nxt;
    logic [2:0]  len;
    logic [31:0] push;
    logic [7:0]  sym;
  } pda_word_t;

  typedef struct packed {
    logic [2:0] status;
    logic [1:0] kind;
    logic [5:0] mst;
    logic [6:0] depth;
    logic [7:0] top;
  } pda_res_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [0:0] cfg_index;
  logic [63:0] cfg_data;

  pae_in_if in_ch();
  pae_out_if out_ch();

  pushdown_automaton_engine_unit u_top (
    .clk(clk), .rst_n(rst_n), .in_if(in_ch), .out_if(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // automaton shadow
  entry_t      tbl [0:255];
  logic [7:0]  stk [0:63];
  int          sdepth;
  logic [5:0]  mstate;
  bit          stuck;
  logic [63:0] acc_mask;
  int          step_limit;

  pda_word_t   pend_words[$];
  pda_res_t    exp_results[$];
  pda_word_t   cur;
  int          src_idle;
  int          snk_idle;
  int          errors;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    repeat (RUN_LIMIT) @(posedge clk);
    $display("DONE: errors detected");
    $finish;
  end

  function automatic logic [7:0] stack_top();
    return (sdepth == 0) ? 8'd0 : stk[sdepth-1];
  endfunction

  function automatic int find_match(logic [7:0] s);
    for (int i = 0; i < 256; i++) begin
      if (!tbl[i].valid) return -1;
      if (tbl[i].st != mstate || tbl[i].sym != s) continue;
      if (sdepth == 0) begin
        if (tbl[i].top == 8'd0) return i;
      end else if (tbl[i].top != 8'd0 && tbl[i].top == stk[sdepth-1]) begin
        return i;
      end
    end
    return -1;
  endfunction

  function automatic bit apply_entry(int i);
    int base;
    int n;
    base = (sdepth == 0) ? 0 : sdepth - 1;
    n = tbl[i].len;
    if (base + n > 64) return 0;
    for (int j = 0; j < n; j++) stk[base+j] = tbl[i].push[8*j +: 8];
    sdepth = base + n;
    mstate = tbl[i].nxt;
    return 1;
  endfunction

  function automatic pda_res_t step_automaton(pda_word_t w);
    pda_res_t r;
    int hit;
    int n;
    int cnt;
    r = '0;
    r.status = ST_OK;
    case (w.cmd)
      CMD_WRITE: begin
        tbl[w.idx].valid = w.ev;
        tbl[w.idx].st = w.st;
        tbl[w.idx].sym = w.msym;
        tbl[w.idx].top = w.mtop;
        tbl[w.idx].nxt = w.nxt;
        tbl[w.idx].len = (w.len > 4) ? 3'd4 : w.len;
        tbl[w.idx].push = w.push;
      end
      CMD_START: begin
        n = (w.len > 4) ? 4 : w.len;
        for (int j = 0; j < n; j++) stk[j] = w.push[8*j +: 8];
        sdepth = n;
        mstate = '0;
        stuck = 0;
      end
      CMD_SYM: begin
        if (stuck) begin
          r.status = ST_STUCK;
        end else begin
          hit = (w.sym == 8'd0) ? -1 : find_match(w.sym);
          if (hit < 0) begin
            stuck = 1;
            r.status = ST_STUCK;
          end else if (!apply_entry(hit)) begin
            stuck = 1;
            r.status = ST_OVFL;
          end
        end
      end
      default: begin
        if (stuck) begin
          r.status = ST_REJECT;
        end else begin
          cnt = 0;
          forever begin
            hit = find_match(8'd0);
            if (hit < 0) break;
            if (cnt >= step_limit) begin
              r.status = ST_REJECT;
              stuck = 1;
              break;
            end
            if (!apply_entry(hit)) begin
              r.status = ST_OVFL;
              stuck = 1;
              break;
            end
            cnt++;
          end
          if (r.status == ST_OK) begin
            if (sdepth == 0) r.kind[0] = 1'b1;
            if (acc_mask[mstate]) r.kind[1] = 1'b1;
            r.status = (r.kind != 2'd0) ? ST_ACCEPT : ST_REJECT;
          end
        end
      end
    endcase
    r.mst = mstate;
    r.depth = sdepth[6:0];
    r.top = stack_top();
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) exp_results.push_back(step_automaton(cur));
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (pend_words.size() > 0 && $urandom_range(99) >= src_idle) begin
        cur = pend_words.pop_front();
        in_ch.cmd <= cur.cmd;
        in_ch.entry_index <= cur.idx;
        in_ch.entry_valid <= cur.ev;
        in_ch.match_state <= cur.st;
        in_ch.match_symbol <= cur.msym;
        in_ch.match_top <= cur.mtop;
        in_ch.next_state <= cur.nxt;
        in_ch.push_len <= cur.len;
        in_ch.push_symbols <= cur.push;
        in_ch.symbol <= cur.sym;
        in_ch.valid <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    pda_res_t got;
    pda_res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = {out_ch.status, out_ch.accept_kind, out_ch.machine_state, out_ch.depth_out,
             out_ch.top_symbol};
      if (exp_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected word status=%0d kind=%0d state=%0d depth=%0d top=%0h",
                 $time, got.status, got.kind, got.mst, got.depth, got.top);
      end else begin
        want = exp_results.pop_front();
        if (got.status !== want.status || got.kind !== want.kind || got.mst !== want.mst ||
            got.depth !== want.depth || got.top !== want.top) begin
          errors++;
          $display("%0t: mismatch expected status=%0d kind=%0d state=%0d depth=%0d top=%0h",
                   $time, want.status, want.kind, want.mst, want.depth, want.top);
          $display("%0t:          actual status=%0d kind=%0d state=%0d depth=%0d top=%0h",
                   $time, got.status, got.kind, got.mst, got.depth, got.top);
        end
      end
    end
    out_ch.ready <= rst_n && ($urandom_range(99) >= snk_idle);
  end

  function automatic pda_word_t noise_word(logic [1:0] c);
    pda_word_t w;
    w.cmd = c;
    w.idx = 8'($urandom_range(255));
    w.ev = 1'($urandom_range(1));
    w.st = 6'($urandom_range(63));
    w.msym = 8'($urandom_range(255));
    w.mtop = 8'($urandom_range(255));
    w.nxt = 6'($urandom_range(63));
    w.len = 3'($urandom_range(7));
    w.push = $urandom;
    w.sym = 8'($urandom_range(255));
    return w;
  endfunction

  task automatic add_entry(int i, bit v, int s, int ms, int mt, int nx, int ln, logic [31:0] p);
    pda_word_t w;
    w = noise_word(CMD_WRITE);
    w.idx = 8'(i);
    w.ev = v;
    w.st = 6'(s);
    w.msym = 8'(ms);
    w.mtop = 8'(mt);
    w.nxt = 6'(nx);
    w.len = 3'(ln);
    w.push = p;
    pend_words.push_back(w);
  endtask

  task automatic add_start(int ln, logic [31:0] p);
    pda_word_t w;
    w = noise_word(CMD_START);
    w.len = 3'(ln);
    w.push = p;
    pend_words.push_back(w);
  endtask

  task automatic add_sym(int s);
    pda_word_t w;
    w = noise_word(CMD_SYM);
    w.sym = 8'(s);
    pend_words.push_back(w);
  endtask

  task automatic add_end();
    pend_words.push_back(noise_word(CMD_END));
  endtask

  function automatic logic [7:0] pick_stack_sym();
    int r;
    r = $urandom_range(99);
    if (r < 85) return 8'(8'h41 + $urandom_range(2));
    if (r < 90) return 8'd0;
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [31:0] pick_push();
    return {pick_stack_sym(), pick_stack_sym(), pick_stack_sym(), pick_stack_sym()};
  endfunction

  task automatic add_random(int nwords);
    int k;
    int runs;
    int nsym;
    int stop_at;
    stop_at = pend_words.size() + nwords;
    while (pend_words.size() < stop_at) begin
      k = $urandom_range(1, 8);
      for (int i = 0; i < k; i++) begin
        add_entry(i, 1,
                  ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(3),
                  ($urandom_range(9) < 3) ? 0 : $urandom_range(1, 3),
                  ($urandom_range(9) < 2) ? 0 : 8'h41 + $urandom_range(2),
                  ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(3),
                  $urandom_range(7), pick_push());
      end
      add_entry(k, 0, $urandom_range(63), $urandom_range(255), $urandom_range(255),
                $urandom_range(63), $urandom_range(7), $urandom);
      if ($urandom_range(3) == 0) pend_words.push_back(noise_word(CMD_WRITE));
      runs = $urandom_range(2, 5);
      for (int r = 0; r < runs; r++) begin
        add_start($urandom_range(7), pick_push());
        nsym = ($urandom_range(9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 6);
        for (int j = 0; j < nsym; j++) begin
          case ($urandom_range(19))
            0: add_sym(0);
            1: add_sym($urandom_range(255));
            default: add_sym($urandom_range(1, 3));
          endcase
        end
        if ($urandom_range(9) != 0) add_end();
        if ($urandom_range(4) == 0) add_end();
        if ($urandom_range(6) == 0) add_sym($urandom_range(1, 3));
      end
    end
  endtask

  task automatic drain();
    while (pend_words.size() > 0 || in_ch.valid || exp_results.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_reg(logic [0:0] i, logic [63:0] d);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= i;
    cfg_data <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (i == CFG_MASK) acc_mask = d;
    else step_limit = d[9:0];
  endtask

  initial begin
    errors = 0;
    src_idle = 29;
    snk_idle = 83;
    for (int i = 0; i < 256; i++) tbl[i] = '0;
    for (int i = 0; i < 64; i++) stk[i] = '0;
    sdepth = 0;
    mstate = '0;
    stuck = 0;
    acc_mask = '0;
    step_limit = 256;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_WRITE;
    in_ch.entry_index = '0;
    in_ch.entry_valid = 1'b0;
    in_ch.match_state = '0;
    in_ch.match_symbol = '0;
    in_ch.match_top = '0;
    in_ch.next_state = '0;
    in_ch.push_len = '0;
    in_ch.push_symbols = '0;
    in_ch.symbol = '0;
    out_ch.ready = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    add_entry(0, 1, 0, 1, 0, 1, 2, 32'h0000_4241);
    add_entry(1, 1, 1, 2, 8'h42, 1, 0, 32'h0);
    add_entry(2, 1, 1, 2, 8'h41, 2, 7, 32'h0043_4343);
    add_entry(3, 1, 1, 3, 8'h41, 1, 0, 32'h0);
    add_entry(4, 1, 1, 0, 0, 5, 0, 32'h0);
    add_entry(5, 1, 0, 0, 8'h44, 0, 4, 32'h4444_4444);
    add_entry(6, 1, 0, 0, 8'h45, 0, 1, 32'h0000_0045);
    add_entry(7, 0, 63, 255, 255, 63, 7, 32'hffff_ffff);
    add_entry(255, 1, 63, 255, 255, 63, 7, 32'hffff_ffff);
    // empty stack acceptance, repeated end of input
    add_start(0, 32'h0);
    add_sym(1);
    add_sym(2);
    add_sym(3);
    add_end();
    add_end();
    // zero on top, stuck, symbol while stuck, end while stuck
    add_start(0, 32'h0);
    add_sym(1);
    add_sym(2);
    add_sym(2);
    add_sym(5);
    add_sym(1);
    add_end();
    // overflow during end of input
    add_start(1, 32'h44);
    add_end();
    add_end();
    // step limit
    add_start(1, 32'h45);
    add_end();
    // long initial stack, zero symbol
    add_start(7, 32'hffff_ffff);
    add_sym(0);
    add_end();
    drain();

    set_reg(CFG_MASK, 64'hffff_ffff_ffff_ffff);
    set_reg(CFG_LIMIT, 64'd1);
    add_random(400);
    drain();

    set_reg(CFG_MASK, 64'd0);
    set_reg(CFG_LIMIT, 64'd1023);
    add_start(1, 32'h45);
    add_end();
    add_start(0, 32'h0);
    add_sym(1);
    add_sym(2);
    add_sym(3);
    add_end();
    drain();

    src_idle = 83;
    snk_idle = 29;
    set_reg(CFG_MASK, {$urandom, $urandom});
    set_reg(CFG_LIMIT, 64'($urandom_range(2, 12)));
    add_random(380);
    drain();

    src_idle = 0;
    snk_idle = 0;
    set_reg(CFG_MASK, {$urandom, $urandom});
    set_reg(CFG_LIMIT, 64'($urandom_range(1, 12)));
    add_random(340);
    drain();

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
